// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define ASSERT_AT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Expression never holds outside reset.
`define ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition");

`endif

// ----- src/ipv6cc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv6cc_pkg
// Types and constants of the IPv6 CIDR text checker.
// ----------------------------------------------------------------------------
package ipv6cc_pkg;

  localparam int unsigned MAX_ADDR_CHARS = 45;
  localparam int unsigned MAX_PREFIX     = 128;

  localparam int unsigned ADDR_LEN_W = $clog2(MAX_ADDR_CHARS + 2);
  localparam int unsigned PREFIX_W   = 8;
  localparam int unsigned DIGITS_W   = 3;
  localparam int unsigned GROUPS_W   = 5;

  localparam logic [PREFIX_W-1:0] PREFIX_SAT       = PREFIX_W'(MAX_PREFIX + 1);
  localparam logic [DIGITS_W-1:0] DIGITS_SAT       = 3'd5;
  localparam logic [DIGITS_W-1:0] MAX_GROUP_DIGITS = 3'd4;
  localparam logic [GROUPS_W-1:0] GROUPS_SAT       = 5'd31;
  localparam logic [GROUPS_W-1:0] FULL_GROUPS      = 5'd8;
  localparam logic [GROUPS_W-1:0] MAX_GROUPS_COMP  = 5'd7;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_COLON,
    CLS_SLASH,
    CLS_DEC,
    CLS_ALPHA,
    CLS_OTHER
  } char_cls_e;

  typedef enum logic [1:0] {
    LERR_NONE,
    LERR_EMPTY,
    LERR_LONG,
    LERR_CHAR
  } loop_err_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_NO_SLASH    = 4'd1,
    ST_BAD_PREFIX  = 4'd2,
    ST_EMPTY_ADDR  = 4'd3,
    ST_TOO_LONG    = 4'd4,
    ST_MULTI_DCOL  = 4'd5,
    ST_EMPTY_GROUP = 4'd6,
    ST_LONG_GROUP  = 4'd7,
    ST_BAD_CHAR    = 4'd8,
    ST_MANY_GROUPS = 4'd9,
    ST_NOT_8       = 4'd10
  } status_e;

  typedef struct packed {
    logic      has_char;
    logic      is_last;
    char_cls_e cls;
    logic [3:0] dec_val;
  } item_t;

endpackage

// ----- src/ipv6_cidr_text_checker_core.sv -----
// ----------------------------------------------------------------------------
// ipv6_cidr_text_checker_core
// Checks an IPv6 CIDR string fed one character per transfer, last one marked,
// and returns one status code per string. A transfer is taken every cycle
// while the four-entry character queue has room; the last character of a
// string passes through the queue and its result is then held in the output
// register, and the scan keeps one character per cycle, stopping only
// at a last character while the previous status still waits to be taken.
// ----------------------------------------------------------------------------
module ipv6_cidr_text_checker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_char_i,
  input  logic       has_char_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] status_o
);
  import ipv6cc_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_valid;

  ipv6cc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_char_i (text_char_i),
    .has_char_i  (has_char_i),
    .is_last_i   (is_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  ipv6cc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  ipv6cc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o)
  );

endmodule

// ----- src/ipv6cc_front.sv -----
// ----------------------------------------------------------------------------
// ipv6cc_front
// Input side: accepts characters and classifies them for the queue.
// ----------------------------------------------------------------------------
module ipv6cc_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         text_char_i,
  input  logic               has_char_i,
  input  logic               is_last_i,
  input  logic               q_full_i,
  output logic               push_o,
  output ipv6cc_pkg::item_t  item_o
);
  import ipv6cc_pkg::*;

  char_cls_e cls;

  always_comb begin
    if (text_char_i == 8'h3A) begin
      cls = CLS_COLON;
    end else if (text_char_i == 8'h2F) begin
      cls = CLS_SLASH;
    end else if (text_char_i >= 8'h30 && text_char_i <= 8'h39) begin
      cls = CLS_DEC;
    end else if ((text_char_i >= 8'h61 && text_char_i <= 8'h66) ||
                 (text_char_i >= 8'h41 && text_char_i <= 8'h46)) begin
      cls = CLS_ALPHA;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign in_ready_o       = !q_full_i;
  assign push_o           = in_valid_i && !q_full_i;
  assign item_o.has_char  = has_char_i;
  assign item_o.is_last   = is_last_i;
  assign item_o.cls       = cls;
  assign item_o.dec_val   = text_char_i[3:0];

endmodule

// ----- src/ipv6cc_fifo.sv -----
// ----------------------------------------------------------------------------
// ipv6cc_fifo
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv6cc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ipv6cc_pkg::item_t  item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ipv6cc_pkg::item_t  item_o
);
  import ipv6cc_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `ASSERT_AT(a_cnt_bound, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
  `ASSERT_NEVER(a_no_overflow, push_i && full_o)
  `ASSERT_NEVER(a_no_underflow, pop_i && !valid_o)
  `ASSERT_AT(a_ptr_gap, (wr_ptr_q - rd_ptr_q) == cnt_q[FIFO_PTR_W-1:0])

endmodule

// ----- src/ipv6cc_back.sv -----
// ----------------------------------------------------------------------------
// ipv6cc_back
// Per-character scan state, final status and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv6cc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ipv6cc_pkg::item_t  item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         status_o
);
  import ipv6cc_pkg::*;

  logic                  slash_q, slash_d;
  logic [ADDR_LEN_W-1:0] len_q, len_d;
  logic                  pend_q, pend_d;
  logic                  prev_col_q, prev_col_d;
  logic [1:0]            pairs_q, pairs_d;
  logic                  dcol_q, dcol_d;
  logic [DIGITS_W-1:0]   dig_q, dig_d;
  logic [GROUPS_W-1:0]   grp_q, grp_d;
  loop_err_e             lerr_q, lerr_d;
  logic [PREFIX_W-1:0]   pval_q, pval_d;
  logic                  pdig_q, pdig_d;
  logic                  pbad_q, pbad_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  status_e               fin;

  // only a last character has to wait for the output register
  assign pop_o       = valid_i && (!item_i.is_last || !out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  always_comb begin
    logic [10:0] prod;
    logic        is_colon;
    logic        is_hex;
    logic        done;
    slash_d    = slash_q;
    len_d      = len_q;
    pend_d     = pend_q;
    prev_col_d = prev_col_q;
    pairs_d    = pairs_q;
    dcol_d     = dcol_q;
    dig_d      = dig_q;
    grp_d      = grp_q;
    lerr_d     = lerr_q;
    pval_d     = pval_q;
    pdig_d     = pdig_q;
    pbad_d     = pbad_q;
    is_colon   = (item_i.cls == CLS_COLON);
    is_hex     = (item_i.cls == CLS_DEC) || (item_i.cls == CLS_ALPHA);
    done       = 1'b0;
    prod = {pval_q, 3'b000} + {2'b00, pval_q, 1'b0} + {7'd0, item_i.dec_val};
    if (pop_o && item_i.has_char) begin
      if (slash_q) begin
        if (item_i.cls == CLS_DEC) begin
          pval_d = (prod > {3'd0, PREFIX_SAT}) ? PREFIX_SAT : prod[PREFIX_W-1:0];
          pdig_d = 1'b1;
        end else begin
          pbad_d = 1'b1;
        end
      end else if (item_i.cls == CLS_SLASH) begin
        slash_d = 1'b1;
      end else begin
        if (len_q <= ADDR_LEN_W'(MAX_ADDR_CHARS)) begin
          len_d = len_q + ADDR_LEN_W'(1);
        end
        if (is_colon && prev_col_q && pairs_q < 2'd2) begin
          pairs_d = pairs_q + 2'd1;
        end
        prev_col_d = is_colon;
        if (pend_q) begin
          pend_d = 1'b0;
          if (is_colon) begin
            dcol_d = 1'b1;
            if (dig_q != '0) begin
              if (dig_q > MAX_GROUP_DIGITS && lerr_d == LERR_NONE) begin
                lerr_d = LERR_LONG;
              end
              grp_d = (grp_q < GROUPS_SAT) ? grp_q + GROUPS_W'(1) : GROUPS_SAT;
              dig_d = '0;
            end
            done = 1'b1;
          end else begin
            if (lerr_d == LERR_NONE) begin
              if (dig_q == '0) begin
                lerr_d = LERR_EMPTY;
              end else if (dig_q > MAX_GROUP_DIGITS) begin
                lerr_d = LERR_LONG;
              end
            end
            grp_d = (grp_q < GROUPS_SAT) ? grp_q + GROUPS_W'(1) : GROUPS_SAT;
            dig_d = '0;
          end
        end
        if (!done) begin
          if (is_colon) begin
            pend_d = 1'b1;
          end else if (!is_hex) begin
            if (lerr_d == LERR_NONE) begin
              lerr_d = LERR_CHAR;
            end
          end else if (dig_d < DIGITS_SAT) begin
            dig_d = dig_d + DIGITS_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    loop_err_e           err;
    logic [DIGITS_W-1:0] dg;
    logic [GROUPS_W-1:0] gr;
    err = lerr_d;
    dg  = dig_d;
    gr  = grp_d;
    if (pend_d) begin
      if (err == LERR_NONE) begin
        if (dg == '0) begin
          err = LERR_EMPTY;
        end else if (dg > MAX_GROUP_DIGITS) begin
          err = LERR_LONG;
        end
      end
      gr = (gr < GROUPS_SAT) ? gr + GROUPS_W'(1) : GROUPS_SAT;
      dg = '0;
    end
    if (dg != '0) begin
      if (dg > MAX_GROUP_DIGITS && err == LERR_NONE) begin
        err = LERR_LONG;
      end
      gr = (gr < GROUPS_SAT) ? gr + GROUPS_W'(1) : GROUPS_SAT;
    end
    if (!slash_d && len_d == '0) begin
      fin = ST_OK;
    end else if (!slash_d) begin
      fin = ST_NO_SLASH;
    end else if (!pdig_d || pbad_d || pval_d > PREFIX_W'(MAX_PREFIX)) begin
      fin = ST_BAD_PREFIX;
    end else if (len_d == '0) begin
      fin = ST_EMPTY_ADDR;
    end else if (len_d > ADDR_LEN_W'(MAX_ADDR_CHARS)) begin
      fin = ST_TOO_LONG;
    end else if (pairs_d >= 2'd2) begin
      fin = ST_MULTI_DCOL;
    end else begin
      case (err)
        LERR_EMPTY: fin = ST_EMPTY_GROUP;
        LERR_LONG:  fin = ST_LONG_GROUP;
        LERR_CHAR:  fin = ST_BAD_CHAR;
        default: begin
          if (dcol_d) begin
            fin = (gr > MAX_GROUPS_COMP) ? ST_MANY_GROUPS : ST_OK;
          end else begin
            fin = (gr != FULL_GROUPS) ? ST_NOT_8 : ST_OK;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    if (pop_o && item_i.is_last) begin
      out_valid_d = 1'b1;
      status_d    = fin;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slash_q     <= 1'b0;
      len_q       <= '0;
      pend_q      <= 1'b0;
      prev_col_q  <= 1'b0;
      pairs_q     <= '0;
      dcol_q      <= 1'b0;
      dig_q       <= '0;
      grp_q       <= '0;
      lerr_q      <= LERR_NONE;
      pval_q      <= '0;
      pdig_q      <= 1'b0;
      pbad_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o && item_i.is_last) begin
        slash_q    <= 1'b0;
        len_q      <= '0;
        pend_q     <= 1'b0;
        prev_col_q <= 1'b0;
        pairs_q    <= '0;
        dcol_q     <= 1'b0;
        dig_q      <= '0;
        grp_q      <= '0;
        lerr_q     <= LERR_NONE;
        pval_q     <= '0;
        pdig_q     <= 1'b0;
        pbad_q     <= 1'b0;
      end else begin
        slash_q    <= slash_d;
        len_q      <= len_d;
        pend_q     <= pend_d;
        prev_col_q <= prev_col_d;
        pairs_q    <= pairs_d;
        dcol_q     <= dcol_d;
        dig_q      <= dig_d;
        grp_q      <= grp_d;
        lerr_q     <= lerr_d;
        pval_q     <= pval_d;
        pdig_q     <= pdig_d;
        pbad_q     <= pbad_d;
      end
    end
  end

  `ASSERT_AT(a_len_sat, len_q <= ADDR_LEN_W'(MAX_ADDR_CHARS + 1))
  `ASSERT_AT(a_dig_sat, dig_q <= DIGITS_SAT && pairs_q <= 2'd2 && pval_q <= PREFIX_SAT)
  `ASSERT_AT(a_clear_after_last, pop_o && item_i.is_last |=> !slash_q && len_q == '0 && !pend_q)
  `ASSERT_AT(a_out_hold, out_valid_q && !out_ready_i |=> out_valid_q && $stable(status_q))
  `ASSERT_AT(a_pend_addr, pend_q |-> prev_col_q && len_q != '0)

endmodule
